>>> rtl/core/pt2d_pkg.sv
// shared types, constants and tables for the 2d point transform
package pt2d_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int STAGES_USED   = (CORDIC_STAGES < 8) ? 8 :
                                  ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int GUARD_BITS = 12;
   localparam int GAIN_BITS  = 30;
   localparam int WORK_W     = 32;
   localparam int PROD_W     = WORK_W + GAIN_BITS + 1;
   localparam int FINAL_W    = 24;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int SCALE_FRAC = 12;

   typedef enum logic [1:0] {
      OP_ROTATE    = 2'd0,
      OP_TRANSLATE = 2'd1,
      OP_SCALE     = 2'd2,
      OP_PASS      = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ANGLE   = 3'd0,
      REG_REF_X   = 3'd1,
      REG_REF_Y   = 3'd2,
      REG_SCALE_X = 3'd3,
      REG_SCALE_Y = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic        [COORD_W-1:0] angle;
      logic signed [COORD_W-1:0] ref_x;
      logic signed [COORD_W-1:0] ref_y;
      logic signed [COORD_W-1:0] scale_x;
      logic signed [COORD_W-1:0] scale_y;
   } cfg_type;

   typedef struct packed {
      op_type                   op;
      logic signed [WORK_W-1:0] x;
      logic signed [WORK_W-1:0] y;
      logic signed [WORK_W-1:0] z;
   } cell_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_out;
      logic signed [COORD_W-1:0] y_out;
      logic                      saturated;
   } result_type;

   // atan(2^-i) in units of 2^32 per turn
   localparam logic signed [WORK_W-1:0] ATAN_TURN32 [0:23] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41721,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   // inverse cordic gain, q30, for 8 to 24 stages
   localparam logic [GAIN_BITS-1:0] GAIN_Q30 [0:16] = '{
      30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978,
      30'd652032900, 30'd652032881, 30'd652032876, 30'd652032874,
      30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
      30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
      30'd652032874
   };

   localparam logic [GAIN_BITS-1:0] GAIN = GAIN_Q30[STAGES_USED-8];

   localparam logic signed [PROD_W-1:0] ROT_HALF =
      PROD_W'(1) << (GAIN_BITS + GUARD_BITS - 1);
   localparam logic signed [PROD_W-1:0] SCALE_HALF = PROD_W'(1) << (SCALE_FRAC - 1);

   localparam logic signed [FINAL_W-1:0] SAT_MAX = FINAL_W'(32767);
   localparam logic signed [FINAL_W-1:0] SAT_MIN = -FINAL_W'(32768);

endpackage

>>> rtl/core/pt2d_ifs.sv
// valid/ready channel interfaces for request, response and register writes
interface pt2d_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            operation;
   logic signed [pt2d_pkg::COORD_W-1:0]   x_in;
   logic signed [pt2d_pkg::COORD_W-1:0]   y_in;
   modport source (output valid, operation, x_in, y_in, input ready);
   modport sink   (input valid, operation, x_in, y_in, output ready);
endinterface

interface pt2d_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pt2d_pkg::COORD_W-1:0]   x_out;
   logic signed [pt2d_pkg::COORD_W-1:0]   y_out;
   logic                                  saturated;
   modport source (output valid, x_out, y_out, saturated, input ready);
   modport sink   (input valid, x_out, y_out, saturated, output ready);
endinterface

interface pt2d_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [pt2d_pkg::CSR_IDX_W-1:0]        index;
   logic [pt2d_pkg::COORD_W-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pt2d_front.sv
// input stage: pivot offset, quarter turn, translate sum, scale products
module pt2d_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [1:0]                           in_op,
   input  logic signed [pt2d_pkg::COORD_W-1:0]  in_x,
   input  logic signed [pt2d_pkg::COORD_W-1:0]  in_y,
   input  pt2d_pkg::cfg_type                    cfg,
   output logic                                 out_valid,
   output pt2d_pkg::cell_type                   out_data
);

   logic                                 valid_ff, valid_in;
   pt2d_pkg::cell_type                   data_ff, data_in;
   logic signed [pt2d_pkg::DIFF_W-1:0]   dx, dy, qx, qy;
   logic        [pt2d_pkg::COORD_W-1:0]  ang_sum, resid;
   logic        [1:0]                    quad;
   logic signed [2*pt2d_pkg::COORD_W-1:0] prod_x, prod_y;
   pt2d_pkg::op_type                     op;

   always_comb begin
      op      = pt2d_pkg::op_type'(in_op);
      dx      = pt2d_pkg::DIFF_W'(in_x) - pt2d_pkg::DIFF_W'(cfg.ref_x);
      dy      = pt2d_pkg::DIFF_W'(in_y) - pt2d_pkg::DIFF_W'(cfg.ref_y);
      ang_sum = cfg.angle + pt2d_pkg::COORD_W'(8192);
      quad    = ang_sum[pt2d_pkg::COORD_W-1 -: 2];
      resid   = cfg.angle - {quad, 14'd0};
      prod_x  = in_x * cfg.scale_x;
      prod_y  = in_y * cfg.scale_y;

      // exact quarter turns before the fine rotation
      unique case (quad)
         2'd0: begin qx = dx;  qy = dy;  end
         2'd1: begin qx = -dy; qy = dx;  end
         2'd2: begin qx = -dx; qy = -dy; end
         default: begin qx = dy; qy = -dx; end
      endcase

      data_in.op = op;
      data_in.z  = {resid, 16'd0};
      unique case (op)
         pt2d_pkg::OP_ROTATE: begin
            data_in.x = pt2d_pkg::WORK_W'(qx) <<< pt2d_pkg::GUARD_BITS;
            data_in.y = pt2d_pkg::WORK_W'(qy) <<< pt2d_pkg::GUARD_BITS;
         end
         pt2d_pkg::OP_TRANSLATE: begin
            data_in.x = pt2d_pkg::WORK_W'(pt2d_pkg::DIFF_W'(in_x) +
                                          pt2d_pkg::DIFF_W'(cfg.ref_x));
            data_in.y = pt2d_pkg::WORK_W'(pt2d_pkg::DIFF_W'(in_y) +
                                          pt2d_pkg::DIFF_W'(cfg.ref_y));
         end
         pt2d_pkg::OP_SCALE: begin
            data_in.x = pt2d_pkg::WORK_W'(prod_x);
            data_in.y = pt2d_pkg::WORK_W'(prod_y);
         end
         default: begin
            data_in.x = pt2d_pkg::WORK_W'(in_x);
            data_in.y = pt2d_pkg::WORK_W'(in_y);
         end
      endcase
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/pt2d_cell.sv
// one cordic micro-rotation cell; other operations pass through untouched
module pt2d_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [pt2d_pkg::SHIFT_W-1:0]         shift,
   input  logic signed [pt2d_pkg::WORK_W-1:0]   atan,
   input  logic                                 in_valid,
   input  pt2d_pkg::cell_type                   in_data,
   output logic                                 out_valid,
   output pt2d_pkg::cell_type                   out_data
);

   logic                                valid_ff, valid_in;
   pt2d_pkg::cell_type                  data_ff, data_in;
   logic signed [pt2d_pkg::WORK_W-1:0]  xs, ys;

   always_comb begin
      xs       = in_data.x >>> shift;
      ys       = in_data.y >>> shift;
      data_in  = in_data;
      valid_in = in_valid;
      if (in_data.op == pt2d_pkg::OP_ROTATE) begin
         if (!in_data.z[pt2d_pkg::WORK_W-1]) begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - atan;
         end else begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/pt2d_back.sv
// gain multiply stage, then rounding, pivot add-back and saturation
module pt2d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  pt2d_pkg::cell_type     in_data,
   input  pt2d_pkg::cfg_type      cfg,
   output logic                   out_valid,
   output pt2d_pkg::result_type   out_result
);

   logic                                valid_ff, valid_in;
   pt2d_pkg::op_type                    op_ff, op_in;
   logic signed [pt2d_pkg::PROD_W-1:0]  wx_ff, wx_in, wy_ff, wy_in;
   logic signed [pt2d_pkg::PROD_W-1:0]  gain_s;
   logic signed [pt2d_pkg::FINAL_W-1:0] fx, fy, sx, sy;
   logic                                flag_x, flag_y;

   function automatic logic signed [pt2d_pkg::FINAL_W-1:0] finish(
      input pt2d_pkg::op_type                  op,
      input logic signed [pt2d_pkg::PROD_W-1:0] w,
      input logic signed [pt2d_pkg::COORD_W-1:0] ref_v
   );
      logic signed [pt2d_pkg::PROD_W-1:0]  rr;
      logic signed [pt2d_pkg::FINAL_W-1:0] v;
      unique case (op)
         pt2d_pkg::OP_ROTATE: begin
            rr = (w + pt2d_pkg::ROT_HALF) >>> (pt2d_pkg::GAIN_BITS + pt2d_pkg::GUARD_BITS);
            v  = pt2d_pkg::FINAL_W'(rr) + pt2d_pkg::FINAL_W'(ref_v);
         end
         pt2d_pkg::OP_SCALE: begin
            rr = (w + pt2d_pkg::SCALE_HALF) >>> pt2d_pkg::SCALE_FRAC;
            v  = pt2d_pkg::FINAL_W'(rr);
         end
         default: begin
            rr = w;
            v  = pt2d_pkg::FINAL_W'(rr);
         end
      endcase
      return v;
   endfunction

   always_comb begin
      gain_s   = pt2d_pkg::PROD_W'({1'b0, pt2d_pkg::GAIN});
      valid_in = in_valid;
      op_in    = in_data.op;
      if (in_data.op == pt2d_pkg::OP_ROTATE) begin
         wx_in = pt2d_pkg::PROD_W'(in_data.x) * gain_s;
         wy_in = pt2d_pkg::PROD_W'(in_data.y) * gain_s;
      end else begin
         wx_in = pt2d_pkg::PROD_W'(in_data.x);
         wy_in = pt2d_pkg::PROD_W'(in_data.y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         op_ff <= op_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   always_comb begin
      fx     = finish(op_ff, wx_ff, cfg.ref_x);
      fy     = finish(op_ff, wy_ff, cfg.ref_y);
      flag_x = (fx > pt2d_pkg::SAT_MAX) || (fx < pt2d_pkg::SAT_MIN);
      flag_y = (fy > pt2d_pkg::SAT_MAX) || (fy < pt2d_pkg::SAT_MIN);
      priority if (fx > pt2d_pkg::SAT_MAX) sx = pt2d_pkg::SAT_MAX;
      else if (fx < pt2d_pkg::SAT_MIN) sx = pt2d_pkg::SAT_MIN;
      else sx = fx;
      priority if (fy > pt2d_pkg::SAT_MAX) sy = pt2d_pkg::SAT_MAX;
      else if (fy < pt2d_pkg::SAT_MIN) sy = pt2d_pkg::SAT_MIN;
      else sy = fy;
      out_result.x_out     = pt2d_pkg::COORD_W'(sx);
      out_result.y_out     = pt2d_pkg::COORD_W'(sy);
      out_result.saturated = flag_x | flag_y;
   end

   assign out_valid = valid_ff;

endmodule

>>> rtl/core/point_transform_2d.sv
// top level of the 2d point transform: registers, cordic cell row, output buffer
//
// usage
//  - req channel: one beat per point, carrying operation (rotate, translate,
//    scale, or pass-through for the spare code) and x_in / y_in in q11.4
//  - rsp channel: one beat per request, in request order, with x_out / y_out
//    saturated to 16 bits and a saturated flag set when either was clipped
//  - csr channel: register index and data; always ready, a write lands on
//    the edge where valid is high; writes to unused indexes are dropped;
//    registers must only change while no request is in flight
//  - every operation passes through the same stages in order: input stage,
//    one cell per cordic stage, gain multiply stage, output register
//  - throughput is one point per clock while req.ready is high; the row of
//    cordic cells is a straight pipeline, so every operation travels the
//    same path
//  - a two-entry output buffer (output register plus skid register) sits at
//    the end; while the receiver stalls the pipeline keeps running until
//    the skid register fills, then req.ready drops and the whole row holds
//  - req.ready comes only from a register, never from rsp.ready
//  - synchronous reset empties the pipeline and the output buffer, sets the
//    angle and reference point to zero and both scale factors to 1.0
module point_transform_2d (
   input  logic        clock,
   input  logic        reset,
   pt2d_req_if.sink    req,
   pt2d_rsp_if.source  rsp,
   pt2d_csr_if.sink    csr
);

   localparam int N = pt2d_pkg::STAGES_USED;

   // configuration registers
   pt2d_pkg::cfg_type cfg_ff, cfg_in;

   // pipeline row
   logic                 advance;
   logic                 cell_valid [0:N];
   pt2d_pkg::cell_type   cell_data  [0:N];
   logic                 back_valid;
   pt2d_pkg::result_type back_result;

   // output register and skid register
   logic                 out_v_ff, out_v_in;
   logic                 skid_v_ff, skid_v_in;
   pt2d_pkg::result_type out_ff, out_in;
   pt2d_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   // register writes
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (pt2d_pkg::csr_idx_type'(csr.index))
            pt2d_pkg::REG_ANGLE:   cfg_in.angle   = csr.data;
            pt2d_pkg::REG_REF_X:   cfg_in.ref_x   = csr.data;
            pt2d_pkg::REG_REF_Y:   cfg_in.ref_y   = csr.data;
            pt2d_pkg::REG_SCALE_X: cfg_in.scale_x = csr.data;
            pt2d_pkg::REG_SCALE_Y: cfg_in.scale_y = csr.data;
            default:               cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle   <= '0;
         cfg_ff.ref_x   <= '0;
         cfg_ff.ref_y   <= '0;
         cfg_ff.scale_x <= pt2d_pkg::COORD_W'(4096);
         cfg_ff.scale_y <= pt2d_pkg::COORD_W'(4096);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the whole row moves together unless the skid register is occupied
   assign advance   = !skid_v_ff;
   assign req.ready = advance;

   pt2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_op     (req.operation),
      .in_x      (req.x_in),
      .in_y      (req.y_in),
      .cfg       (cfg_ff),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0])
   );

   // one cell per cordic stage, stage index sets the shift and the angle step
   for (genvar g = 0; g < N; g++) begin : g_cell
      pt2d_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .shift     (pt2d_pkg::SHIFT_W'(g)),
         .atan      (pt2d_pkg::ATAN_TURN32[g]),
         .in_valid  (cell_valid[g]),
         .in_data   (cell_data[g]),
         .out_valid (cell_valid[g+1]),
         .out_data  (cell_data[g+1])
      );
   end

   pt2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (cell_valid[N]),
      .in_data    (cell_data[N]),
      .cfg        (cfg_ff),
      .out_valid  (back_valid),
      .out_result (back_result)
   );

   // output buffer
   assign pop = out_v_ff && rsp.ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // row is frozen, drain the skid entry once the output beat goes
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (out_v_ff && !pop) begin
         // output stalled, catch the beat leaving the row
         if (back_valid) begin
            skid_in   = back_result;
            skid_v_in = 1'b1;
         end
      end else begin
         out_in   = back_result;
         out_v_in = back_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.x_out     = out_ff.x_out;
   assign rsp.y_out     = out_ff.y_out;
   assign rsp.saturated = out_ff.saturated;

endmodule

>>> rtl/core/pt2d_checker.sv
// port-level checks for the 2d point transform, bound to the top level
module pt2d_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [pt2d_pkg::COORD_W-1:0]  rsp_x_out,
   input logic signed [pt2d_pkg::COORD_W-1:0]  rsp_y_out,
   input logic                                 rsp_saturated
);

   // a stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled response beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x_out) && $stable(rsp_y_out)
                                  && $stable(rsp_saturated))
      else $error("response payload changed while stalled");

   // reset empties the output buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the request side only backs up while a response is waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no pending response");

   // a clipped result sits on a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_x_out == 16'sh7fff) || (rsp_x_out == 16'sh8000) ||
         (rsp_y_out == 16'sh7fff) || (rsp_y_out == 16'sh8000))
      else $error("saturated flag without a clipped coordinate");

endmodule

bind point_transform_2d pt2d_checker u_pt2d_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_x_out     (rsp.x_out),
   .rsp_y_out     (rsp.y_out),
   .rsp_saturated (rsp.saturated)
);
